### rtl/gbs_pkg.sv
// Package: widths, types and constants shared by the box suppression block.
package gbs_pkg;

    localparam int MAX_BOXES    = 64;
    localparam int COORD_BITS   = 16;
    localparam int SCORE_W      = 16;
    localparam int THR_W        = 9;
    localparam int THR_FRAC     = 8;
    localparam int RESULT_LIMIT = 64;
    localparam int OUT_IDX_W    = 6;

    localparam int IDX_W   = $clog2(MAX_BOXES);
    localparam int CNT_W   = $clog2(MAX_BOXES + 1);
    localparam int PICK_W  = $clog2(RESULT_LIMIT + 1);
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int INTER_W = 2 * COORD_BITS;
    localparam int AREA_W  = 2 * DIFF_W;
    localparam int UNION_W = AREA_W + 2;
    localparam int PROD_W  = THR_W + UNION_W - 1;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(128);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] left;
        logic signed [COORD_BITS-1:0] top;
        logic signed [COORD_BITS-1:0] right;
        logic signed [COORD_BITS-1:0] bottom;
    } t_box;

    // Tag that travels alongside one entry through the overlap pipeline.
    typedef struct packed {
        logic               vld;
        logic [IDX_W-1:0]   idx;
        logic [SCORE_W-1:0] score;
    } t_tag;

endpackage

### rtl/gbs_store.sv
// Box and score memories: one write port, one registered read port.
module gbs_store (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [gbs_pkg::IDX_W-1:0]     i_wr_addr,
    input  gbs_pkg::t_box                 i_wr_box,
    input  logic [gbs_pkg::SCORE_W-1:0]   i_wr_score,
    input  logic [gbs_pkg::IDX_W-1:0]     i_rd_addr,
    output gbs_pkg::t_box                 o_rd_box,
    output logic [gbs_pkg::SCORE_W-1:0]   o_rd_score
);
    import gbs_pkg::*;

    t_box               box_mem   [MAX_BOXES];
    logic [SCORE_W-1:0] score_mem [MAX_BOXES];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            box_mem[i_wr_addr]   <= i_wr_box;
            score_mem[i_wr_addr] <= i_wr_score;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_box   <= box_mem[i_rd_addr];
        o_rd_score <= score_mem[i_rd_addr];
    end

endmodule

### rtl/gbs_iou.sv
// Four-stage overlap pipeline: decides whether the reference box suppresses an entry.
module gbs_iou (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  gbs_pkg::t_tag                     i_tag,
    input  gbs_pkg::t_box                     i_box,
    input  logic                              i_ref_valid,
    input  gbs_pkg::t_box                     i_ref,
    input  logic signed [gbs_pkg::AREA_W-1:0] i_ref_area,
    input  logic [gbs_pkg::THR_W-1:0]         i_thr,
    output gbs_pkg::t_tag                     o_tag,
    output logic                              o_supp,
    output logic                              o_busy
);
    import gbs_pkg::*;

    // stage 1: overlap extents and candidate sides
    logic signed [COORD_BITS-1:0] max_l, max_t, min_r, min_d;
    logic signed [DIFF_W-1:0]     ow, oh, bw, bh;

    t_tag                     r1_tag;
    logic [COORD_BITS-1:0]    r1_w, r1_h;
    logic signed [DIFF_W-1:0] r1_bw, r1_bh;

    // stage 2: products
    t_tag                     r2_tag;
    logic [INTER_W-1:0]       r2_inter;
    logic signed [AREA_W-1:0] r2_area;

    // stage 3: union
    t_tag                      r3_tag;
    logic [INTER_W-1:0]        r3_inter;
    logic signed [UNION_W-1:0] r3_union;

    // stage 4: threshold test
    t_tag               r4_tag;
    logic               r4_supp;
    logic [PROD_W-1:0]  lhs, prod;
    logic               n_supp;

    assign max_l = (i_ref.left   > i_box.left)   ? i_ref.left   : i_box.left;
    assign max_t = (i_ref.top    > i_box.top)    ? i_ref.top    : i_box.top;
    assign min_r = (i_ref.right  < i_box.right)  ? i_ref.right  : i_box.right;
    assign min_d = (i_ref.bottom < i_box.bottom) ? i_ref.bottom : i_box.bottom;

    assign ow = DIFF_W'(min_r) - DIFF_W'(max_l);
    assign oh = DIFF_W'(min_d) - DIFF_W'(max_t);
    assign bw = DIFF_W'(i_box.right)  - DIFF_W'(i_box.left);
    assign bh = DIFF_W'(i_box.bottom) - DIFF_W'(i_box.top);

    assign lhs  = PROD_W'({r3_inter, {THR_FRAC{1'b0}}});
    assign prod = PROD_W'(i_thr) * PROD_W'(r3_union[UNION_W-2:0]);

    // zero union suppresses; negative union keeps
    always_comb begin
        n_supp = 1'b0;
        if (i_ref_valid) begin
            if (r3_union == '0) begin
                n_supp = 1'b1;
            end else if (!r3_union[UNION_W-1]) begin
                n_supp = (lhs > prod);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_tag.vld <= 1'b0;
            r2_tag.vld <= 1'b0;
            r3_tag.vld <= 1'b0;
            r4_tag.vld <= 1'b0;
        end else begin
            r1_tag.vld <= i_tag.vld;
            r2_tag.vld <= r1_tag.vld;
            r3_tag.vld <= r2_tag.vld;
            r4_tag.vld <= r3_tag.vld;
        end

        r1_tag.idx   <= i_tag.idx;
        r1_tag.score <= i_tag.score;
        r1_w         <= ow[DIFF_W-1] ? '0 : ow[COORD_BITS-1:0];
        r1_h         <= oh[DIFF_W-1] ? '0 : oh[COORD_BITS-1:0];
        r1_bw        <= bw;
        r1_bh        <= bh;

        r2_tag.idx   <= r1_tag.idx;
        r2_tag.score <= r1_tag.score;
        r2_inter     <= INTER_W'(r1_w) * INTER_W'(r1_h);
        r2_area      <= AREA_W'(r1_bw) * AREA_W'(r1_bh);

        r3_tag.idx   <= r2_tag.idx;
        r3_tag.score <= r2_tag.score;
        r3_inter     <= r2_inter;
        r3_union     <= UNION_W'(i_ref_area) + UNION_W'(r2_area) - UNION_W'(r2_inter);

        r4_tag.idx   <= r3_tag.idx;
        r4_tag.score <= r3_tag.score;
        r4_supp      <= n_supp;
    end

    assign o_tag  = r4_tag;
    assign o_supp = r4_supp;
    assign o_busy = r1_tag.vld | r2_tag.vld | r3_tag.vld | r4_tag.vld;

endmodule

### rtl/greedy_box_suppression_top.sv
// Top level: greedy IoU box suppression with sequencer, live flags and result register.
//
//  channel   direction  handshake                     payload
//  -------   ---------  ----------------------------  ------------------------------------
//  box in    into       i_in_valid / o_in_stall       i_box_left/top/right/bottom,
//                                                     i_box_score, i_is_last_box
//  kept out  out of     o_out_valid / i_out_stall     o_kept_index, o_is_last_kept,
//                                                     o_overflowed
//  config    into       i_cfg_valid / o_cfg_ready     i_iou_threshold
//
//  Loading accepts one box transaction per cycle. Once the last box lands, each pick costs
//  one sweep of the stored set through the memory read port and the overlap pipeline, so a
//  set with K kept boxes takes K + 1 sweeps, each paced by the single memory read port.
//  Reset (i_rst_n low, synchronous) empties the set and restores a threshold of 128.
//  Box transactions are stalled for the whole suppression; a stalled result holds the
//  sequencer only when the next result is ready to go out.
module greedy_box_suppression_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // box input
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [gbs_pkg::COORD_BITS-1:0]  i_box_left,
    input  logic signed [gbs_pkg::COORD_BITS-1:0]  i_box_top,
    input  logic signed [gbs_pkg::COORD_BITS-1:0]  i_box_right,
    input  logic signed [gbs_pkg::COORD_BITS-1:0]  i_box_bottom,
    input  logic [gbs_pkg::SCORE_W-1:0]            i_box_score,
    input  logic                                   i_is_last_box,
    // kept index output
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [gbs_pkg::OUT_IDX_W-1:0]          o_kept_index,
    output logic                                   o_is_last_kept,
    output logic                                   o_overflowed,
    // threshold write
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [gbs_pkg::THR_W-1:0]              i_iou_threshold
);
    import gbs_pkg::*;

    localparam logic [1:0] ST_LOAD   = 2'd0;  // take box transactions
    localparam logic [1:0] ST_SCAN   = 2'd1;  // sweep the set through the pipeline
    localparam logic [1:0] ST_DECIDE = 2'd2;  // emit a result, pick the next box
    localparam logic [1:0] ST_FETCH  = 2'd3;  // latch the picked box as reference

    logic [1:0]              r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count;
    logic                    r_ovf, n_ovf;
    logic [MAX_BOXES-1:0]    r_live, n_live;
    logic [THR_W-1:0]        r_thr;
    logic [CNT_W-1:0]        r_scan_idx, n_scan_idx;
    logic                    r_rd_vld;
    logic [IDX_W-1:0]        r_rd_idx;
    logic                    r_have_best, n_have_best;
    logic                    r_cand_v, n_cand_v;
    logic [IDX_W-1:0]        r_cand_idx, n_cand_idx;
    logic [SCORE_W-1:0]      r_cand_score, n_cand_score;
    logic                    r_pend_v, n_pend_v;
    logic [IDX_W-1:0]        r_pend_idx, n_pend_idx;
    logic [PICK_W-1:0]       r_picked, n_picked;
    t_box                    r_ref, n_ref;
    logic signed [AREA_W-1:0] r_ref_area, n_ref_area;

    logic                    r_out_vld, n_out_vld;
    logic [OUT_IDX_W-1:0]    r_out_idx, n_out_idx;
    logic                    r_out_last, n_out_last;
    logic                    r_out_ovf, n_out_ovf;

    logic                    in_acc, wr_en, issue, out_free, set_done, keep;
    logic [IDX_W-1:0]        rd_addr;
    t_box                    wr_box, rd_box;
    logic [SCORE_W-1:0]      rd_score;
    t_tag                    pipe_in, pipe_out;
    logic                    pipe_supp, pipe_busy;
    logic signed [DIFF_W-1:0] ref_w, ref_h;

    assign o_in_stall  = (r_state != ST_LOAD);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign wr_en       = in_acc && (r_count < CNT_W'(MAX_BOXES));
    assign issue       = (r_state == ST_SCAN) && (r_scan_idx < r_count);
    assign out_free    = !r_out_vld || !i_out_stall;
    // the set ends when no live box remains or the result limit is reached
    assign set_done    = !r_cand_v || (r_picked == PICK_W'(RESULT_LIMIT));

    assign wr_box = '{left: i_box_left, top: i_box_top, right: i_box_right,
                      bottom: i_box_bottom};

    // the memory port serves the sweep, or the picked box while deciding
    assign rd_addr = (r_state == ST_DECIDE) ? r_cand_idx : r_scan_idx[IDX_W-1:0];

    gbs_store u_store (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_addr  (r_count[IDX_W-1:0]),
        .i_wr_box   (wr_box),
        .i_wr_score (i_box_score),
        .i_rd_addr  (rd_addr),
        .o_rd_box   (rd_box),
        .o_rd_score (rd_score)
    );

    assign pipe_in = '{vld: r_rd_vld, idx: r_rd_idx, score: rd_score};

    gbs_iou u_iou (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tag       (pipe_in),
        .i_box       (rd_box),
        .i_ref_valid (r_have_best),
        .i_ref       (r_ref),
        .i_ref_area  (r_ref_area),
        .i_thr       (r_thr),
        .o_tag       (pipe_out),
        .o_supp      (pipe_supp),
        .o_busy      (pipe_busy)
    );

    // area of the picked box, taken straight from the memory read data
    assign ref_w = DIFF_W'(rd_box.right)  - DIFF_W'(rd_box.left);
    assign ref_h = DIFF_W'(rd_box.bottom) - DIFF_W'(rd_box.top);

    // an entry survives the sweep if it was live and the reference does not suppress it
    assign keep = r_live[pipe_out.idx] && !pipe_supp;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_ovf        = r_ovf;
        n_live       = r_live;
        n_scan_idx   = r_scan_idx;
        n_have_best  = r_have_best;
        n_cand_v     = r_cand_v;
        n_cand_idx   = r_cand_idx;
        n_cand_score = r_cand_score;
        n_pend_v     = r_pend_v;
        n_pend_idx   = r_pend_idx;
        n_picked     = r_picked;
        n_ref        = r_ref;
        n_ref_area   = r_ref_area;
        n_out_vld    = r_out_vld && i_out_stall;
        n_out_idx    = r_out_idx;
        n_out_last   = r_out_last;
        n_out_ovf    = r_out_ovf;

        case (r_state)
            ST_LOAD: begin
                if (in_acc) begin
                    if (wr_en) begin
                        n_live[r_count[IDX_W-1:0]] = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_is_last_box) begin
                        n_state     = ST_SCAN;
                        n_scan_idx  = '0;
                        n_cand_v    = 1'b0;
                        n_have_best = 1'b0;
                        n_picked    = '0;
                        n_pend_v    = 1'b0;
                    end
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    n_scan_idx = r_scan_idx + CNT_W'(1);
                end
                // retire one entry: drop it if suppressed, track the best survivor
                if (pipe_out.vld) begin
                    n_live[pipe_out.idx] = keep;
                    if (keep && (!r_cand_v || pipe_out.score > r_cand_score)) begin
                        n_cand_v     = 1'b1;
                        n_cand_idx   = pipe_out.idx;
                        n_cand_score = pipe_out.score;
                    end
                end
                if (!issue && !r_rd_vld && !pipe_busy) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                // hold while the previous pick cannot go out yet
                if (!r_pend_v || out_free) begin
                    if (r_pend_v) begin
                        n_out_vld  = 1'b1;
                        n_out_idx  = OUT_IDX_W'(r_pend_idx);
                        n_out_last = set_done;
                        n_out_ovf  = r_ovf;
                    end
                    if (set_done) begin
                        n_state  = ST_LOAD;
                        n_live   = '0;
                        n_count  = '0;
                        n_ovf    = 1'b0;
                        n_pend_v = 1'b0;
                    end else begin
                        n_state              = ST_FETCH;
                        n_pend_v             = 1'b1;
                        n_pend_idx           = r_cand_idx;
                        n_picked             = r_picked + PICK_W'(1);
                        n_live[r_cand_idx]   = 1'b0;
                    end
                end
            end
            ST_FETCH: begin
                n_ref       = rd_box;
                n_ref_area  = AREA_W'(ref_w) * AREA_W'(ref_h);
                n_have_best = 1'b1;
                n_cand_v    = 1'b0;
                n_scan_idx  = '0;
                n_state     = ST_SCAN;
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_live      <= '0;
            r_thr       <= THR_RESET;
            r_scan_idx  <= '0;
            r_rd_vld    <= 1'b0;
            r_have_best <= 1'b0;
            r_cand_v    <= 1'b0;
            r_pend_v    <= 1'b0;
            r_picked    <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_live      <= n_live;
            if (i_cfg_valid && o_cfg_ready) begin
                r_thr <= i_iou_threshold;
            end
            r_scan_idx  <= n_scan_idx;
            r_rd_vld    <= issue;
            r_have_best <= n_have_best;
            r_cand_v    <= n_cand_v;
            r_pend_v    <= n_pend_v;
            r_picked    <= n_picked;
            r_out_vld   <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx     <= r_scan_idx[IDX_W-1:0];
        r_cand_idx   <= n_cand_idx;
        r_cand_score <= n_cand_score;
        r_pend_idx   <= n_pend_idx;
        r_ref        <= n_ref;
        r_ref_area   <= n_ref_area;
        r_out_idx    <= n_out_idx;
        r_out_last   <= n_out_last;
        r_out_ovf    <= n_out_ovf;
    end

    assign o_out_valid    = r_out_vld;
    assign o_kept_index   = r_out_idx;
    assign o_is_last_kept = r_out_last;
    assign o_overflowed   = r_out_ovf;

    // pipeline results only arrive while a sweep is under way
    a_pipe_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pipe_out.vld |-> (r_state == ST_SCAN))
        else $error("overlap result outside a sweep");

    // the box just picked is retired before its sweep
    a_pick_retired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FETCH) |-> !r_live[r_pend_idx])
        else $error("picked box still live");

    // the running best of a sweep is always a live box
    a_cand_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SCAN) && r_cand_v) |-> r_live[r_cand_idx])
        else $error("candidate not live");

    // the fill count never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |=> (r_count <= CNT_W'(MAX_BOXES)))
        else $error("box count beyond store depth");

endmodule
